// ===== rtl/vcf_pkg.sv =====
// ----------------------------------------------------------------------------
// vcf_pkg
// shared types and constants of the vertex component to float converter
// ----------------------------------------------------------------------------
package vcf_pkg;

  typedef enum logic [2:0] {
    FMT_FLOAT = 3'd0,
    FMT_U16   = 3'd1,
    FMT_S16   = 3'd2,
    FMT_U8    = 3'd3,
    FMT_S8    = 3'd4,
    FMT_U32   = 3'd5,
    FMT_S32   = 3'd6,
    FMT_NONE  = 3'd7
  } fmt_e;

  typedef enum logic {
    REG_FORMAT    = 1'b0,
    REG_NORMALIZE = 1'b1
  } reg_idx_e;

  localparam int unsigned MantW = 48;
  localparam int unsigned LzW   = 6;

  localparam logic [31:0] OneBits = 32'h3F80_0000;

  // biased exponent of the top window bit
  localparam logic [7:0] ExpInt    = 8'd158; // weight 2^31
  localparam logic [7:0] ExpFrac   = 8'd126; // weight 2^-1
  localparam logic [7:0] ExpS32Nrm = 8'd127; // 2^31 / 2^31

  typedef struct packed {
    logic               byp;
    logic [31:0]        byp_bits;
    logic               sign;
    logic [7:0]         expo;
    logic               inf_sticky;
    logic [MantW-1:0]   mant;
  } stage_t;

endpackage

// ===== rtl/vcf_prep.sv =====
// ----------------------------------------------------------------------------
// vcf_prep
// decodes the raw component into sign, window and exponent, or a fixed result
// ----------------------------------------------------------------------------
module vcf_prep import vcf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] raw_bits_i,
  input  fmt_e        fmt_i,
  input  logic        nrm_i,
  output logic        valid_o,
  output stage_t      stage_o
);

  stage_t     st_d, st_q;
  logic       valid_q;
  logic [15:0] mag16;
  logic [7:0]  mag8;
  logic [31:0] mag32;

  always_comb begin
    st_d            = '0;
    st_d.byp        = 1'b1;
    mag16           = raw_bits_i[15] ? 16'(-raw_bits_i[15:0]) : raw_bits_i[15:0];
    mag8            = raw_bits_i[7] ? 8'(-raw_bits_i[7:0]) : raw_bits_i[7:0];
    mag32           = raw_bits_i[31] ? 32'(-raw_bits_i) : raw_bits_i;
    case (fmt_i)
      FMT_FLOAT: st_d.byp_bits = raw_bits_i;
      FMT_U16: begin
        if (!nrm_i) begin
          st_d.byp  = (raw_bits_i[15:0] == 16'd0);
          st_d.expo = ExpInt;
          st_d.mant = {16'd0, raw_bits_i[15:0], 16'd0};
        end else if (raw_bits_i[15:0] == 16'hFFFF) begin
          st_d.byp_bits = OneBits;
        end else begin
          // v / (2^16 - 1) is v repeated in 16-bit blocks
          st_d.byp        = (raw_bits_i[15:0] == 16'd0);
          st_d.expo       = ExpFrac;
          st_d.inf_sticky = 1'b1;
          st_d.mant = {raw_bits_i[15:0], raw_bits_i[15:0], raw_bits_i[15:0]};
        end
      end
      FMT_S16: begin
        st_d.sign = raw_bits_i[15];
        if (!nrm_i) begin
          st_d.byp  = (mag16 == 16'd0);
          st_d.expo = ExpInt;
          st_d.mant = {16'd0, mag16, 16'd0};
        end else if (mag16 >= 16'd32767) begin
          // exact one, or clamped to minus one
          st_d.byp_bits = {raw_bits_i[15], OneBits[30:0]};
        end else begin
          st_d.byp        = (mag16 == 16'd0);
          st_d.expo       = ExpFrac;
          st_d.inf_sticky = 1'b1;
          st_d.mant = {mag16[14:0], mag16[14:0], mag16[14:0], 3'd0};
        end
      end
      FMT_U8: begin
        if (!nrm_i) begin
          st_d.byp  = (raw_bits_i[7:0] == 8'd0);
          st_d.expo = ExpInt;
          st_d.mant = {24'd0, raw_bits_i[7:0], 16'd0};
        end else if (raw_bits_i[7:0] == 8'hFF) begin
          st_d.byp_bits = OneBits;
        end else begin
          st_d.byp        = (raw_bits_i[7:0] == 8'd0);
          st_d.expo       = ExpFrac;
          st_d.inf_sticky = 1'b1;
          st_d.mant = {6{raw_bits_i[7:0]}};
        end
      end
      FMT_S8: begin
        st_d.sign = raw_bits_i[7];
        if (!nrm_i) begin
          st_d.byp  = (mag8 == 8'd0);
          st_d.expo = ExpInt;
          st_d.mant = {24'd0, mag8, 16'd0};
        end else if (mag8 >= 8'd127) begin
          st_d.byp_bits = {raw_bits_i[7], OneBits[30:0]};
        end else begin
          st_d.byp        = (mag8 == 8'd0);
          st_d.expo       = ExpFrac;
          st_d.inf_sticky = 1'b1;
          st_d.mant = {{6{mag8[6:0]}}, 6'd0};
        end
      end
      FMT_U32: begin
        st_d.byp  = (raw_bits_i == 32'd0);
        st_d.expo = nrm_i ? ExpFrac : ExpInt;
        st_d.mant = {raw_bits_i, 16'd0};
      end
      FMT_S32: begin
        st_d.sign = raw_bits_i[31];
        st_d.byp  = (raw_bits_i == 32'd0);
        st_d.expo = nrm_i ? ExpS32Nrm : ExpInt;
        st_d.mant = {mag32, 16'd0};
      end
      default: st_d.byp_bits = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign valid_o = valid_q;
  assign stage_o = st_q;

endmodule

// ===== rtl/vcf_lzc.sv =====
// ----------------------------------------------------------------------------
// vcf_lzc
// leading zero count of the window, registered with the stage data
// ----------------------------------------------------------------------------
module vcf_lzc import vcf_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  stage_t         stage_i,
  output logic           valid_o,
  output stage_t         stage_o,
  output logic [LzW-1:0] lz_o
);

  logic           valid_q;
  stage_t         st_q;
  logic [LzW-1:0] lz_d, lz_q;

  always_comb begin
    lz_d = '0;
    for (int i = 0; i < MantW; i++) begin
      if (stage_i.mant[i]) begin
        lz_d = LzW'(MantW - 1 - i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= stage_i;
    lz_q <= lz_d;
  end

  assign valid_o = valid_q;
  assign stage_o = st_q;
  assign lz_o    = lz_q;

endmodule

// ===== rtl/vcf_norm_round.sv =====
// ----------------------------------------------------------------------------
// vcf_norm_round
// normalizing shift, then round to nearest even and pack
// ----------------------------------------------------------------------------
module vcf_norm_round import vcf_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  stage_t         stage_i,
  input  logic [LzW-1:0] lz_i,
  output logic           valid_o,
  output logic [31:0]    bits_o
);

  stage_t      sh_d, sh_q;
  logic        v3_q, v4_q;
  logic [24:0] sum;
  logic        up;
  logic [7:0]  expo;
  logic [31:0] res_d, res_q;

  always_comb begin
    sh_d      = stage_i;
    sh_d.mant = stage_i.mant << lz_i;
    sh_d.expo = stage_i.expo - 8'(lz_i);
  end

  always_comb begin
    up   = sh_q.mant[23] & (sh_q.inf_sticky | (|sh_q.mant[22:0]) | sh_q.mant[24]);
    sum  = {1'b0, sh_q.mant[47:24]} + 25'(up);
    expo = sh_q.expo + 8'(sum[24]);
    if (sh_q.byp) begin
      res_d = sh_q.byp_bits;
    end else begin
      // a carry out leaves an all-zero fraction
      res_d = {sh_q.sign, expo, sum[24] ? 23'd0 : sum[22:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    res_q <= res_d;
  end

  assign valid_o = v4_q;
  assign bits_o  = res_q;

endmodule

// ===== rtl/vertex_component_to_float_core.sv =====
// ----------------------------------------------------------------------------
// vertex_component_to_float_core
// converts one raw vertex attribute component to an ieee single per cycle
// ----------------------------------------------------------------------------
// usage
//   - set component_format (index 0) and normalize_enable (index 1) through
//     cfg_we_i / cfg_idx_i / cfg_wdata_i while no transfer is in flight
//   - a component transfer happens on a clock edge with start_i high and
//     busy_o low; busy_o is always low, so one component per cycle is taken
//   - the result shows on float_bits_o with done_o high for exactly one
//     cycle for each start transfer, in the order of the transfers
//   - throughput is one item per cycle; the four register stages are:
//     decode, leading zero count, normalizing shift, round and pack
//   - results come out in start order and cannot be held off
//   - reset clears the stage valid bits and sets format float, normalize off;
//     items in flight at reset are dropped
// ----------------------------------------------------------------------------
module vertex_component_to_float_core import vcf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] raw_bits_i,
  output logic        done_o,
  output logic [31:0] float_bits_o
);

  fmt_e           fmt_q;
  logic           nrm_q;
  logic           v1, v2;
  stage_t         s1, s2;
  logic [LzW-1:0] lz2;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_FLOAT;
      nrm_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FORMAT:    fmt_q <= fmt_e'(cfg_wdata_i);
        REG_NORMALIZE: nrm_q <= cfg_wdata_i[0];
        default:       ;
      endcase
    end
  end

  // fully pipelined, never stalls
  assign busy_o = 1'b0;

  vcf_prep u_prep (
    .clk_i, .rst_ni,
    .valid_i    (start_i),
    .raw_bits_i,
    .fmt_i      (fmt_q),
    .nrm_i      (nrm_q),
    .valid_o    (v1),
    .stage_o    (s1)
  );

  vcf_lzc u_lzc (
    .clk_i, .rst_ni,
    .valid_i (v1),
    .stage_i (s1),
    .valid_o (v2),
    .stage_o (s2),
    .lz_o    (lz2)
  );

  vcf_norm_round u_round (
    .clk_i, .rst_ni,
    .valid_i (v2),
    .stage_i (s2),
    .lz_i    (lz2),
    .valid_o (done_o),
    .bits_o  (float_bits_o)
  );

endmodule

// ===== rtl/vcf_checker.sv =====
// ----------------------------------------------------------------------------
// vcf_checker
// port level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
module vcf_checker import vcf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [31:0] raw_bits_i,
  input logic        done_o,
  input logic [31:0] float_bits_o
);

  logic [2:0] settle_q;
  logic       settled;

  // counts edges out of reset until the whole pipe has been refilled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 3'd0;
    end else if (settle_q != 3'd4) begin
      settle_q <= settle_q + 3'd1;
    end
  end

  assign settled = (settle_q == 3'd4);

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled |-> (done_o == $past(start_i && !busy_o, 4)))
    else $error("done does not follow start by four cycles");

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  a_zero_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settled && $past(start_i && raw_bits_i == 32'd0, 4)) |-> float_bits_o == 32'd0)
    else $error("zero component did not give zero");

endmodule

bind vertex_component_to_float_core vcf_checker u_vcf_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .raw_bits_i, .done_o, .float_bits_o
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the vertex component to float converter against a bit exact
// predictor over all formats, both normalize settings and random traffic
// ----------------------------------------------------------------------------
module tb import vcf_pkg::*; ();

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [2:0]  cfg_wdata_i;
  logic        start_i;
  logic        busy_o;
  logic [31:0] raw_bits_i;
  logic        done_o;
  logic [31:0] float_bits_o;

  // settings the predictor works with, updated on each register write
  fmt_e        cur_fmt;
  logic        cur_nrm;

  // predicted float patterns, oldest first
  logic [31:0] float_queue[$];
  int unsigned n_errors;
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_settings;

  vertex_component_to_float_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .raw_bits_i   (raw_bits_i),
    .done_o       (done_o),
    .float_bits_o (float_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // sign and magnitude to single, round to nearest even
  function automatic logic [31:0] int_to_single(logic neg, logic [31:0] mag);
    int          top;
    int          sh;
    logic [31:0] rem;
    logic [31:0] half;
    logic [31:0] keep;
    if (mag == 32'd0) return 32'd0;
    top = 31;
    while (!mag[top]) top--;
    if (top <= 23) begin
      keep = mag << (23 - top);
    end else begin
      sh   = top - 23;
      rem  = mag & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      keep = mag >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep == 32'h0100_0000) begin
        keep = keep >> 1;
        top++;
      end
    end
    return {neg, 8'(top + 127), keep[22:0]};
  endfunction

  // small integer over an odd denominator, correctly rounded single
  function automatic logic [31:0] div_single(int v, int unsigned den, logic clamp);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    int          sh;
    int          ex;
    neg = (v < 0);
    mag = neg ? 64'(-v) : 64'(v);
    if (mag == 64'd0) return 32'd0;
    // below -1 pins to exactly -1
    if (clamp && neg && mag > 64'(den)) return {1'b1, OneBits[30:0]};
    sh = 0;
    while (((mag << sh) / den) < 64'h80_0000) sh++;
    num = mag << sh;
    quo = num / den;
    rem = num % den;
    if (2 * rem > 64'(den) || (2 * rem == 64'(den) && quo[0])) quo++;
    ex = 150 - sh;
    if (quo == 64'h100_0000) begin
      quo = quo >> 1;
      ex++;
    end
    return {neg, 8'(ex), quo[22:0]};
  endfunction

  // exponent shift for the 32-bit normalized formats, zero untouched
  function automatic logic [31:0] scale_down(logic [31:0] bits, int unsigned k);
    if (bits[30:0] == 31'd0) return bits;
    return bits - (32'(k) << 23);
  endfunction

  function automatic logic [31:0] decode_component(fmt_e f, logic nrm, logic [31:0] raw);
    logic [31:0] mag;
    int          sv;
    case (f)
      FMT_FLOAT: return raw;
      FMT_U16: return nrm ? div_single(int'(raw[15:0]), 65535, 1'b0)
                          : int_to_single(1'b0, {16'd0, raw[15:0]});
      FMT_S16: begin
        sv = int'($signed(raw[15:0]));
        if (nrm) return div_single(sv, 32767, 1'b1);
        return int_to_single(sv < 0, 32'(sv < 0 ? -sv : sv));
      end
      FMT_U8: return nrm ? div_single(int'(raw[7:0]), 255, 1'b0)
                         : int_to_single(1'b0, {24'd0, raw[7:0]});
      FMT_S8: begin
        sv = int'($signed(raw[7:0]));
        if (nrm) return div_single(sv, 127, 1'b1);
        return int_to_single(sv < 0, 32'(sv < 0 ? -sv : sv));
      end
      FMT_U32: begin
        mag = raw;
        return nrm ? scale_down(int_to_single(1'b0, mag), 32) : int_to_single(1'b0, mag);
      end
      FMT_S32: begin
        mag = raw[31] ? (32'd0 - raw) : raw;
        return nrm ? scale_down(int_to_single(raw[31], mag), 31)
                   : int_to_single(raw[31], mag);
      end
      default: return 32'd0;
    endcase
  endfunction

  // result checks come before the prediction of a new transfer at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        n_results++;
        if (float_queue.size() == 0) begin
          $error("float_bits: result 0x%08h with no transfer pending", float_bits_o);
          n_errors++;
        end else begin
          if (float_bits_o !== float_queue[0]) begin
            $error("float_bits: expected 0x%08h actual 0x%08h", float_queue[0], float_bits_o);
            n_errors++;
          end
          void'(float_queue.pop_front());
        end
      end
      if (start_i && !busy_o) begin
        float_queue.insert(float_queue.size(),
                           decode_component(cur_fmt, cur_nrm, raw_bits_i));
        n_items++;
      end
    end
  end

  // wait for the pipeline to empty; four stages plus margin
  task automatic drain();
    start_i <= 1'b0;
    while (float_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [2:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == REG_FORMAT) cur_fmt = fmt_e'(data);
    else cur_nrm = data[0];
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_mode(fmt_e f, logic nrm);
    drain();
    write_reg(REG_FORMAT, 3'(f));
    write_reg(REG_NORMALIZE, {2'b00, nrm});
    n_settings++;
  endtask

  // start stays high; the caller lowers it only for a gap
  task automatic send_component(logic [31:0] raw);
    start_i    <= 1'b1;
    raw_bits_i <= raw;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic test_directed();
    set_mode(FMT_FLOAT, 1'b1);
    send_component(32'h7FC0_0001);  // nan passes through
    send_component(32'hFF80_0000);
    set_mode(FMT_U8, 1'b1);
    send_component(32'hFFFF_FF00);  // upper bits ignored
    send_component(32'h0000_00FF);
    set_mode(FMT_S8, 1'b1);
    send_component(32'h0000_0080);  // most negative clamps to -1
    send_component(32'h0000_007F);
    send_component(32'h0000_0081);
    set_mode(FMT_U16, 1'b1);
    send_component(32'h0000_FFFF);
    send_component(32'h1234_0001);
    set_mode(FMT_S16, 1'b1);
    send_component(32'h0000_8000);
    send_component(32'hFFFF_7FFF);
    set_mode(FMT_S16, 1'b0);
    send_component(32'h0000_8000);
    set_mode(FMT_U32, 1'b0);
    send_component(32'hFFFF_FFFF);  // rounds up to 2^32
    send_component(32'h0100_0001);  // tie to even, down
    send_component(32'h0100_0003);  // tie to even, up
    send_component(32'h0000_0000);
    set_mode(FMT_S32, 1'b1);
    send_component(32'h8000_0000);  // exactly -1 via exponent shift
    send_component(32'hFFFF_FFFF);
    set_mode(FMT_S32, 1'b0);
    send_component(32'h7FFF_FFFF);
    set_mode(FMT_U32, 1'b1);
    send_component(32'h0000_0001);
    set_mode(FMT_NONE, 1'b0);
    send_component(32'hFFFF_FFFF);  // unsupported gives zero
  endtask

  function automatic logic [31:0] pick_raw();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return r >> $urandom_range(0, 31);             // small magnitudes
      3: return {r[31:8], $urandom_range(0, 1) ? 8'h80 : 8'h7F};
      4: return {r[31:16], $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF};
      5: return {$urandom_range(0, 1) ? 8'h80 : 8'h7F, r[23:0]};
      default: return r;
    endcase
  endfunction

  task automatic test_random();
    int burst;
    for (int ph = 0; ph < 20; ph++) begin
      // first passes hit the corner settings, the rest are random
      if (ph < 2) set_mode(ph == 0 ? FMT_FLOAT : FMT_NONE, ph[0]);
      else if (ph < 4) set_mode(ph == 2 ? FMT_S32 : FMT_U8, ph[0]);
      else set_mode(fmt_e'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      burst = $urandom_range(1, 12);
      for (int i = 0; i < 100; i++) begin
        send_component(pick_raw());
        if (--burst == 0) begin
          burst = $urandom_range(1, 12);
          if ($urandom_range(0, 3) == 0) begin
            start_i <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk_i);
          end
        end
        // occasional full pause until everything in flight is back
        if ($urandom_range(0, 99) == 0) drain();
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    n_errors    = 0;
    n_items     = 0;
    n_results   = 0;
    n_settings  = 0;
    cur_fmt     = FMT_FLOAT;
    cur_nrm     = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_FORMAT;
    cfg_wdata_i = 3'd0;
    start_i     = 1'b0;
    raw_bits_i  = 32'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random();
    drain();

    $display("covered %0d transfers, %0d results, %0d format/normalize settings",
             n_items, n_results, n_settings);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
